FILE: hw/rtl/i2ctmq_pkg.sv
// ----------------------------------------------------------------------------
// i2ctmq_pkg
// Shared codes and control structures of the I2C target message queue.
// ----------------------------------------------------------------------------
`default_nettype none

package i2ctmq_pkg;

    localparam logic [2:0] FUNC_WR_START  = 3'd0;
    localparam logic [2:0] FUNC_BYTE_RX   = 3'd1;
    localparam logic [2:0] FUNC_RD_START  = 3'd2;
    localparam logic [2:0] FUNC_RD_DONE   = 3'd3;
    localparam logic [2:0] FUNC_STOP      = 3'd4;
    localparam logic [2:0] FUNC_HOST_TAKE = 3'd5;
    localparam logic [2:0] FUNC_HOST_PUT  = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic [7:0] IDLE_BYTE = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic take_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic take_stream;
        logic take_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2ctmq_ram.sv
// ----------------------------------------------------------------------------
// i2ctmq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/i2ctmq_ctrl.sv
// ----------------------------------------------------------------------------
// i2ctmq_ctrl
// Sequencer: accepts one item, executes it, and walks the bytes of a take.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctmq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire i2ctmq_pkg::sts_t  sts,
    output i2ctmq_pkg::cmd_t       cmd
);
    import i2ctmq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TAKE_RD,
        S_TAKE_OUT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;

    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd.accept    = in_ready_reg && in_valid;
        cmd.exec      = (state_reg == S_EXEC) && sts.out_free;
        cmd.take_load = (state_reg == S_TAKE_OUT) && sts.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= S_EXEC;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    if (sts.out_free)
                    begin
                        if (sts.take_stream)
                        begin
                            state_reg <= S_TAKE_RD;
                        end
                        else
                        begin
                            state_reg    <= S_IDLE;
                            in_ready_reg <= 1'b1;
                        end
                    end
                end
                S_TAKE_RD:
                begin
                    state_reg <= S_TAKE_OUT;
                end
                S_TAKE_OUT:
                begin
                    if (sts.out_free)
                    begin
                        if (sts.take_last)
                        begin
                            state_reg    <= S_IDLE;
                            in_ready_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_TAKE_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/i2ctmq_dp.sv
// ----------------------------------------------------------------------------
// i2ctmq_dp
// Datapath: ring pointers, message stores, length tables and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctmq_dp #(
    parameter int MSG_SIZE    = 32,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [6:0]        cfg_wr_data,
    input  wire i2ctmq_pkg::cmd_t  cmd,
    output i2ctmq_pkg::sts_t       sts,
    input  wire logic [2:0]        func,
    input  wire logic [7:0]        data,
    input  wire logic [5:0]        host_limit,
    input  wire logic              host_last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             result_byte,
    output logic [1:0]             status,
    output logic [5:0]             msg_length,
    output logic                   more_pending,
    output logic                   new_message,
    output logic                   last
);
    import i2ctmq_pkg::*;

    localparam int LEN_W  = $clog2(MSG_SIZE + 1);
    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int STORE_DEPTH = QUEUE_DEPTH * MSG_SIZE;
    localparam int AW     = $clog2(STORE_DEPTH);
    localparam logic [LEN_W-1:0] MSG_LEN = LEN_W'(MSG_SIZE);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] x);
        logic [SLOT_W-1:0] r;
        if (x == SLOT_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = x + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [LEN_W-1:0]  idx);
        return AW'(slot) * AW'(MSG_SIZE) + AW'(idx);
    endfunction

    function automatic logic [5:0] len6(input logic [LEN_W-1:0] l);
        logic [LEN_W+5:0] w;
        w = {6'd0, l};
        return w[5:0];
    endfunction

    // Architectural state.
    logic [6:0]        own_addr_reg;
    logic [SLOT_W-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [LEN_W-1:0]  rx_len_reg, rx_len_next;
    logic              rx_trunc_reg, rx_trunc_next;
    logic              bus_rd_reg, bus_rd_next;
    logic [SLOT_W-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [LEN_W-1:0]  tx_fill_reg, tx_fill_next;
    logic              tx_ovf_reg, tx_ovf_next;
    logic [LEN_W-1:0]  rd_idx_reg, rd_idx_next;

    // Latched item and take walk.
    logic [2:0]        func_reg;
    logic [7:0]        data_reg;
    logic [5:0]        limit_reg;
    logic              hlast_reg;
    logic [LEN_W-1:0]  take_idx_reg, take_idx_next;
    logic [LEN_W-1:0]  take_len_reg, take_len_next;
    logic              take_more_reg, take_more_next;

    // Result register.
    logic              ov_reg;
    logic [7:0]        rb_reg, rb_next;
    logic [1:0]        st_reg, st_next;
    logic [5:0]        ml_reg, ml_next;
    logic              mp_reg, mp_next;
    logic              nm_reg, nm_next;
    logic              ls_reg, ls_next;
    logic              load;

    // Memory ports.
    logic              rxs_we, txs_we, rxl_we, txl_we;
    logic [AW-1:0]     rxs_waddr, txs_waddr;
    logic [7:0]        rxs_wdata, txs_wdata, rxs_rdata, txs_rdata;
    logic [LEN_W-1:0]  rxl_rdata, txl_rdata, txl_wdata;

    i2ctmq_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_rx_store (
        .clk(clk), .we(rxs_we), .waddr(rxs_waddr), .wdata(rxs_wdata),
        .raddr(store_addr(rx_tail_reg, take_idx_reg)), .rdata(rxs_rdata)
    );

    i2ctmq_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_tx_store (
        .clk(clk), .we(txs_we), .waddr(txs_waddr), .wdata(txs_wdata),
        .raddr(store_addr(tx_tail_reg, rd_idx_reg)), .rdata(txs_rdata)
    );

    i2ctmq_ram #(.WIDTH(LEN_W), .DEPTH(QUEUE_DEPTH)) u_rx_lengths (
        .clk(clk), .we(rxl_we), .waddr(rx_head_reg), .wdata(rx_len_reg),
        .raddr(rx_tail_reg), .rdata(rxl_rdata)
    );

    i2ctmq_ram #(.WIDTH(LEN_W), .DEPTH(QUEUE_DEPTH)) u_tx_lengths (
        .clk(clk), .we(txl_we), .waddr(tx_head_reg), .wdata(txl_wdata),
        .raddr(tx_tail_reg), .rdata(txl_rdata)
    );

    always_comb
    begin
        logic             rx_empty;
        logic             tx_empty;
        logic [LEN_W-1:0] fill_n;
        logic [1:0]       pst;

        rx_empty = (rx_tail_reg == rx_head_reg);
        tx_empty = (tx_tail_reg == tx_head_reg);
        fill_n   = tx_fill_reg;
        pst      = ST_OK;

        sts.out_free  = !ov_reg || out_ready;
        sts.take_last = (LEN_W'(take_idx_reg + 1'b1) == take_len_reg);

        rx_head_next   = rx_head_reg;
        rx_tail_next   = rx_tail_reg;
        rx_len_next    = rx_len_reg;
        rx_trunc_next  = rx_trunc_reg;
        bus_rd_next    = bus_rd_reg;
        tx_head_next   = tx_head_reg;
        tx_tail_next   = tx_tail_reg;
        tx_fill_next   = tx_fill_reg;
        tx_ovf_next    = tx_ovf_reg;
        rd_idx_next    = rd_idx_reg;
        take_idx_next  = take_idx_reg;
        take_len_next  = take_len_reg;
        take_more_next = take_more_reg;

        rxs_we    = 1'b0;
        rxs_waddr = store_addr(rx_head_reg, rx_len_reg);
        rxs_wdata = data_reg;
        txs_we    = 1'b0;
        txs_waddr = store_addr(tx_head_reg, tx_fill_reg);
        txs_wdata = data_reg;
        rxl_we    = 1'b0;
        txl_we    = 1'b0;
        txl_wdata = tx_fill_reg;

        sts.take_stream = 1'b0;
        load    = 1'b0;
        rb_next = 8'd0;
        st_next = ST_OK;
        ml_next = 6'd0;
        mp_next = 1'b0;
        nm_next = 1'b0;
        ls_next = 1'b1;

        if (cmd.accept)
        begin
            take_idx_next = '0;
        end

        if (cmd.exec)
        begin
            load = 1'b1;
            case (func_reg)
                FUNC_WR_START:
                begin
                    bus_rd_next   = 1'b0;
                    rx_trunc_next = 1'b0;
                    rxs_we        = 1'b1;
                    rxs_waddr     = store_addr(rx_head_reg, '0);
                    rxs_wdata     = {own_addr_reg, 1'b0};
                    rx_len_next   = LEN_W'(1);
                    ml_next       = 6'd1;
                end
                FUNC_BYTE_RX:
                begin
                    if (rx_len_reg < MSG_LEN)
                    begin
                        rxs_we      = 1'b1;
                        rx_len_next = rx_len_reg + 1'b1;
                        ml_next     = len6(rx_len_reg + 1'b1);
                    end
                    else
                    begin
                        rx_trunc_next = 1'b1;
                        st_next       = ST_REJECT;
                        ml_next       = len6(rx_len_reg);
                    end
                end
                FUNC_RD_START, FUNC_RD_DONE:
                begin
                    if (func_reg == FUNC_RD_START)
                    begin
                        bus_rd_next = 1'b1;
                    end
                    if (tx_empty)
                    begin
                        rb_next = IDLE_BYTE;
                        st_next = ST_NONE;
                    end
                    else if (rd_idx_reg < txl_rdata && rd_idx_reg < MSG_LEN)
                    begin
                        rb_next     = txs_rdata;
                        rd_idx_next = rd_idx_reg + 1'b1;
                        ml_next     = len6(txl_rdata);
                    end
                    else
                    begin
                        rb_next = IDLE_BYTE;
                        st_next = ST_NONE;
                        ml_next = len6(txl_rdata);
                    end
                end
                FUNC_STOP:
                begin
                    if (!bus_rd_reg)
                    begin
                        ml_next = len6(rx_len_reg);
                        if (rx_trunc_reg || rx_len_reg < LEN_W'(2))
                        begin
                            st_next = ST_REJECT;
                        end
                        else
                        begin
                            // The finished length is written to the table at the old head slot as the head moves.
                            rxl_we       = 1'b1;
                            rx_head_next = next_slot(rx_head_reg);
                            rx_len_next  = '0;
                            if (rx_tail_reg == next_slot(rx_head_reg))
                            begin
                                rx_tail_next = next_slot(rx_tail_reg);
                            end
                            nm_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ml_next = tx_empty ? 6'd0 : len6(txl_rdata);
                        if (rd_idx_reg == txl_rdata)
                        begin
                            if (!tx_empty)
                            begin
                                tx_tail_next = next_slot(tx_tail_reg);
                            end
                            rd_idx_next = '0;
                        end
                    end
                end
                FUNC_HOST_TAKE:
                begin
                    if (rx_empty)
                    begin
                        st_next = ST_NONE;
                    end
                    else if ({6'd0, rxl_rdata} > {{LEN_W{1'b0}}, limit_reg} ||
                             rxl_rdata == '0)
                    begin
                        rx_tail_next = next_slot(rx_tail_reg);
                        mp_next = (next_slot(rx_tail_reg) != rx_head_reg);
                        ml_next = len6(rxl_rdata);
                        st_next = (rxl_rdata == '0) ? ST_OK : ST_TOO_LONG;
                    end
                    else
                    begin
                        // The bytes follow one at a time; the tail moves after the last.
                        load            = 1'b0;
                        sts.take_stream = 1'b1;
                        take_len_next   = rxl_rdata;
                        take_more_next  = (next_slot(rx_tail_reg) != rx_head_reg);
                    end
                end
                FUNC_HOST_PUT:
                begin
                    if (tx_fill_reg < MSG_LEN)
                    begin
                        txs_we = 1'b1;
                        fill_n = tx_fill_reg + 1'b1;
                    end
                    else
                    begin
                        tx_ovf_next = 1'b1;
                        pst         = ST_REJECT;
                    end
                    tx_fill_next = fill_n;
                    ml_next      = len6(fill_n);
                    if (hlast_reg)
                    begin
                        if (tx_ovf_next || next_slot(tx_head_reg) == tx_tail_reg)
                        begin
                            pst = ST_REJECT;
                        end
                        else
                        begin
                            txl_we       = 1'b1;
                            txl_wdata    = fill_n;
                            tx_head_next = next_slot(tx_head_reg);
                        end
                        tx_fill_next = '0;
                        tx_ovf_next  = 1'b0;
                    end
                    st_next = pst;
                end
                default:
                begin
                    rb_next = IDLE_BYTE;
                    st_next = ST_NONE;
                end
            endcase
        end

        if (cmd.take_load)
        begin
            load    = 1'b1;
            rb_next = rxs_rdata;
            ml_next = len6(take_len_reg);
            mp_next = take_more_reg;
            ls_next = sts.take_last;
            take_idx_next = take_idx_reg + 1'b1;
            if (sts.take_last)
            begin
                rx_tail_next = next_slot(rx_tail_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg  <= '0;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            rx_len_reg    <= '0;
            rx_trunc_reg  <= 1'b0;
            bus_rd_reg    <= 1'b0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            tx_fill_reg   <= '0;
            tx_ovf_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            take_idx_reg  <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                own_addr_reg <= cfg_wr_data;
            end
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            rx_len_reg   <= rx_len_next;
            rx_trunc_reg <= rx_trunc_next;
            bus_rd_reg   <= bus_rd_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            tx_fill_reg  <= tx_fill_next;
            tx_ovf_reg   <= tx_ovf_next;
            rd_idx_reg   <= rd_idx_next;
            take_idx_reg <= take_idx_next;
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg  <= func;
            data_reg  <= data;
            limit_reg <= host_limit;
            hlast_reg <= host_last;
        end
        take_len_reg  <= take_len_next;
        take_more_reg <= take_more_next;
        if (load)
        begin
            rb_reg <= rb_next;
            st_reg <= st_next;
            ml_reg <= ml_next;
            mp_reg <= mp_next;
            nm_reg <= nm_next;
            ls_reg <= ls_next;
        end
    end

    assign out_valid    = ov_reg;
    assign result_byte  = rb_reg;
    assign status       = st_reg;
    assign msg_length   = ml_reg;
    assign more_pending = mp_reg;
    assign new_message  = nm_reg;
    assign last         = ls_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_target_message_queue.sv
// An item is accepted and then executed once the result register is free; the block
// takes no new item until it is done with the current one.
// Each result is registered; a host take reads each byte from the store (registered
// store read, S_TAKE_RD) and gives it out in S_TAKE_OUT, one byte at a time.
// Reset (rst_n, asynchronous) empties both rings and clears the address register;
// stores and length tables are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// i2c_target_message_queue
// I2C target with a receive message ring and a transmit message ring.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_target_message_queue #(
    parameter int MSG_SIZE    = 32,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [6:0] cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] func,
    input  wire logic [7:0] data,
    input  wire logic [5:0] host_limit,
    input  wire logic       host_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      result_byte,
    output logic [1:0]      status,
    output logic [5:0]      msg_length,
    output logic            more_pending,
    output logic            new_message,
    output logic            last
);
    import i2ctmq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    i2ctmq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .sts(sts), .cmd(cmd)
    );

    i2ctmq_dp #(.MSG_SIZE(MSG_SIZE), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .cmd(cmd), .sts(sts), .func(func), .data(data), .host_limit(host_limit),
        .host_last(host_last), .out_valid(out_valid), .out_ready(out_ready),
        .result_byte(result_byte), .status(status), .msg_length(msg_length),
        .more_pending(more_pending), .new_message(new_message), .last(last)
    );

endmodule

`default_nettype wire

FILE: test/tmq_checker.sv
// ----------------------------------------------------------------------------
// tmq_checker
// Watches both channels and the address register of the message queue,
// predicts every result item from its own copy of the rings, and compares
// each accepted result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [6:0] cfg_wr_data,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [2:0] func,
    input  wire logic [7:0] data,
    input  wire logic [5:0] host_limit,
    input  wire logic       host_last,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] result_byte,
    input  wire logic [1:0] status,
    input  wire logic [5:0] msg_length,
    input  wire logic       more_pending,
    input  wire logic       new_message,
    input  wire logic       last,
    output int              mismatches,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import i2ctmq_pkg::*;

    localparam int MSG  = 32;
    localparam int RING = 8;

    typedef struct packed {
        logic [7:0] rbyte;
        logic [1:0] st;
        logic [5:0] len;
        logic       more;
        logic       fresh;
        logic       fin;
    } msg_result_t;

    msg_result_t expected_results[$];

    logic [6:0] addr;
    logic [7:0] rx_mem [RING*MSG];
    int         rx_len [RING];
    int         rx_h, rx_t;
    logic       rx_trunc, reading;
    logic [7:0] tx_mem [RING*MSG];
    int         tx_len [RING];
    int         tx_h, tx_t, tx_fill, rd_idx;
    logic       tx_ovf;

    function automatic int nxt(int x);
        return (x + 1 >= RING) ? 0 : x + 1;
    endfunction

    function automatic void push(logic [7:0] b, logic [1:0] st, int len,
                                 logic more, logic fresh, logic fin);
        msg_result_t r;
        r.rbyte = b;
        r.st    = st;
        r.len   = len[5:0];
        r.more  = more;
        r.fresh = fresh;
        r.fin   = fin;
        expected_results.push_back(r);
    endfunction

    function automatic void bus_read();
        int len;
        if (tx_t == tx_h)
        begin
            push(IDLE_BYTE, ST_NONE, 0, 0, 0, 1);
            return;
        end
        len = tx_len[tx_t];
        if (rd_idx < len && rd_idx < MSG)
        begin
            push(tx_mem[tx_t*MSG + rd_idx], ST_OK, len, 0, 0, 1);
            rd_idx++;
        end
        else
            push(IDLE_BYTE, ST_NONE, len, 0, 0, 1);
    endfunction

    function automatic void predict_queue(logic [2:0] f, logic [7:0] d,
                                          logic [5:0] lim, logic hl);
        int len;
        int slot;
        logic more;
        logic [1:0] st;
        case (f)
            FUNC_WR_START:
            begin
                reading  = 0;
                rx_trunc = 0;
                rx_mem[rx_h*MSG] = {addr, 1'b0};
                rx_len[rx_h] = 1;
                push(8'h00, ST_OK, 1, 0, 0, 1);
            end
            FUNC_BYTE_RX:
            begin
                len = rx_len[rx_h];
                if (len < MSG)
                begin
                    rx_mem[rx_h*MSG + len] = d;
                    rx_len[rx_h] = len + 1;
                    push(8'h00, ST_OK, len + 1, 0, 0, 1);
                end
                else
                begin
                    rx_trunc = 1;
                    push(8'h00, ST_REJECT, len, 0, 0, 1);
                end
            end
            FUNC_RD_START:
            begin
                reading = 1;
                bus_read();
            end
            FUNC_RD_DONE: bus_read();
            FUNC_STOP:
            begin
                if (!reading)
                begin
                    len = rx_len[rx_h];
                    if (rx_trunc || len < 2)
                        push(8'h00, ST_REJECT, len, 0, 0, 1);
                    else
                    begin
                        rx_h = nxt(rx_h);
                        rx_len[rx_h] = 0;
                        // A full ring loses its oldest message.
                        if (rx_t == rx_h)
                            rx_t = nxt(rx_t);
                        push(8'h00, ST_OK, len, 0, 1, 1);
                    end
                end
                else
                begin
                    len = (tx_t != tx_h) ? tx_len[tx_t] : 0;
                    if (rd_idx == tx_len[tx_t])
                    begin
                        if (tx_t != tx_h)
                            tx_t = nxt(tx_t);
                        rd_idx = 0;
                    end
                    push(8'h00, ST_OK, len, 0, 0, 1);
                end
            end
            FUNC_HOST_TAKE:
            begin
                if (rx_t == rx_h)
                    push(8'h00, ST_NONE, 0, 0, 0, 1);
                else
                begin
                    slot = rx_t;
                    len  = rx_len[slot];
                    if (len > MSG)
                        len = MSG;
                    rx_t = nxt(rx_t);
                    more = (rx_t != rx_h);
                    if (len > int'(lim) || len == 0)
                        push(8'h00, (len == 0) ? ST_OK : ST_TOO_LONG, len, more, 0, 1);
                    else
                        for (int i = 0; i < len; i++)
                            push(rx_mem[slot*MSG + i], ST_OK, len, more, 0, i + 1 == len);
                end
            end
            FUNC_HOST_PUT:
            begin
                st = ST_OK;
                if (tx_fill < MSG)
                begin
                    tx_mem[tx_h*MSG + tx_fill] = d;
                    tx_fill++;
                end
                else
                begin
                    tx_ovf = 1;
                    st = ST_REJECT;
                end
                len = tx_fill;
                if (hl)
                begin
                    if (tx_ovf || nxt(tx_h) == tx_t)
                        st = ST_REJECT;
                    else
                    begin
                        tx_len[tx_h] = tx_fill;
                        tx_h = nxt(tx_h);
                    end
                    tx_fill = 0;
                    tx_ovf  = 0;
                end
                push(8'h00, st, len, 0, 0, 1);
            end
            default: push(IDLE_BYTE, ST_NONE, 0, 0, 0, 1);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        msg_result_t want, got;
        if (!rst_n)
        begin
            expected_results.delete();
            addr = 0;
            rx_h = 0; rx_t = 0; rx_trunc = 0; reading = 0;
            tx_h = 0; tx_t = 0; tx_fill = 0; rd_idx = 0; tx_ovf = 0;
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // Results are checked before the input of the same edge is
            // predicted; a fresh item cannot answer in the cycle it is taken.
            if (out_valid && out_ready)
            begin
                got = '{result_byte, status, msg_length, more_pending, new_message, last};
                if (expected_results.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t unexpected result item %p", $realtime, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%0t mismatch: expected %p, got %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (cfg_wr_en)
                addr = cfg_wr_data;
            if (in_valid && in_ready)
                predict_queue(func, data, host_limit, host_last);
            outstanding <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives bus events and host requests into the I2C target message queue in
// random bursts under random output stalls, across several bus addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import i2ctmq_pkg::*;

    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       cfg_wr_en = 0;
    logic [6:0] cfg_wr_data = 0;
    logic       in_valid = 0;
    logic       in_ready;
    logic [2:0] func = 0;
    logic [7:0] data = 0;
    logic [5:0] host_limit = 0;
    logic       host_last = 0;
    logic       out_valid;
    logic       out_ready = 0;
    logic [7:0] result_byte;
    logic [1:0] status;
    logic [5:0] msg_length;
    logic       more_pending, new_message, last;
    int         mismatches, outstanding;

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    i2c_target_message_queue u_dut (.*);
    tmq_checker u_chk (.*);

    // Receiver stalls follow a randomly chosen mode that is redrawn when its run ends.
    int stall_mode = 0, stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Light tracking of the transmit ring and bus direction, enough to keep
    // every item away from length entries that were never written.
    int   tr_h = 0, tr_t = 0, tr_fill = 0, tr_idx = 0;
    logic tr_ovf = 0, tr_reading = 0, wr_opened = 0;
    int   tr_len [8];
    logic tr_written [8] = '{default: 1'b0};
    int   burst_left = 0;
    int   sent = 0;

    function automatic int ring_next(int x);
        return (x + 1 >= 8) ? 0 : x + 1;
    endfunction

    task automatic issue(logic [2:0] f, logic [7:0] d, logic [5:0] lim, logic hl);
        if (!wr_opened && (f == FUNC_BYTE_RX || (f == FUNC_STOP && !tr_reading)))
            f = FUNC_WR_START;
        if (f == FUNC_STOP && tr_reading && tr_t == tr_h && !tr_written[tr_t])
            f = FUNC_RD_START;
        case (f)
            FUNC_WR_START:
            begin
                tr_reading = 0;
                wr_opened  = 1;
            end
            FUNC_RD_START, FUNC_RD_DONE:
            begin
                if (f == FUNC_RD_START)
                    tr_reading = 1;
                if (tr_t != tr_h && tr_idx < tr_len[tr_t])
                    tr_idx++;
            end
            FUNC_STOP:
                if (tr_reading && tr_idx == tr_len[tr_t])
                begin
                    if (tr_t != tr_h)
                        tr_t = ring_next(tr_t);
                    tr_idx = 0;
                end
            FUNC_HOST_PUT:
            begin
                if (tr_fill < 32)
                    tr_fill++;
                else
                    tr_ovf = 1;
                if (hl)
                begin
                    if (!(tr_ovf || ring_next(tr_h) == tr_t))
                    begin
                        tr_len[tr_h] = tr_fill;
                        tr_written[tr_h] = 1;
                        tr_h = ring_next(tr_h);
                    end
                    tr_fill = 0;
                    tr_ovf  = 0;
                end
            end
            default: ;
        endcase
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid   <= 1'b1;
        func       <= f;
        data       <= d;
        host_limit <= lim;
        host_last  <= hl;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_address(logic [6:0] a);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic bus_write(int n);
        issue(FUNC_WR_START, $urandom, $urandom, $urandom);
        for (int i = 0; i < n; i++)
            issue(FUNC_BYTE_RX, $urandom, $urandom, $urandom);
        issue(FUNC_STOP, $urandom, $urandom, $urandom);
    endtask

    task automatic bus_read(int n);
        issue(FUNC_RD_START, $urandom, $urandom, $urandom);
        for (int i = 0; i < n; i++)
            issue(FUNC_RD_DONE, $urandom, $urandom, $urandom);
        issue(FUNC_STOP, $urandom, $urandom, $urandom);
    endtask

    task automatic host_message(int n);
        for (int i = 0; i < n; i++)
            issue(FUNC_HOST_PUT, $urandom, $urandom, i == n - 1);
    endtask

    task automatic random_phase(int count);
        int n;
        while (sent < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 35)
                                                    : $urandom_range(0, 6);
                    bus_write(n);
                end
                3, 4: bus_read($urandom_range(0, 6));
                5, 6:
                    issue(FUNC_HOST_TAKE, $urandom,
                          ($urandom_range(0, 2) == 0) ? 6'($urandom) : 6'd63, $urandom);
                7, 8:
                begin
                    n = ($urandom_range(0, 12) == 0) ? $urandom_range(32, 34)
                                                     : $urandom_range(1, 5);
                    host_message(n);
                end
                default: issue($urandom, $urandom, $urandom, $urandom);
            endcase
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_address(7'h7F);

        // Directed opening: every operation and the empty and edge cases.
        issue(FUNC_STOP, 8'h00, 6'd0, 1'b0);
        issue(FUNC_BYTE_RX, 8'h00, 6'd0, 1'b0);
        issue(FUNC_BYTE_RX, 8'hFF, 6'd63, 1'b1);
        issue(FUNC_STOP, 8'h00, 6'd0, 1'b0);
        issue(FUNC_HOST_TAKE, 8'h00, 6'd63, 1'b0);
        issue(FUNC_HOST_TAKE, 8'h00, 6'd63, 1'b0);
        bus_write(0);
        bus_write(2);
        issue(FUNC_HOST_TAKE, 8'hFF, 6'd0, 1'b0);
        issue(FUNC_RD_START, 8'h00, 6'd0, 1'b0);
        host_message(2);
        bus_read(3);
        issue(FUNC_UNUSED, 8'hFF, 6'd63, 1'b1);
        issue(FUNC_RD_DONE, 8'h00, 6'd0, 1'b0);
        wait_drained();

        set_address(7'h00);
        random_phase(100);
        // The host lets everything drain before the next address.
        wait_drained();
        set_address(7'($urandom));
        random_phase(180);
        wait_drained();
        set_address(7'h55);
        random_phase(260);
        wait_drained();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: i2c_target_message_queue.f
hw/rtl/i2ctmq_pkg.sv
hw/rtl/i2ctmq_ram.sv
hw/rtl/i2ctmq_ctrl.sv
hw/rtl/i2ctmq_dp.sv
hw/rtl/i2c_target_message_queue.sv
test/tmq_checker.sv
test/tb_top.sv
